// File: design/capture_period_frequency_meter_defines.svh
// ----------------------------------------------------------------------------
// capture_period_frequency_meter_defines
// Assertion macros shared by the checker of the frequency meter.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_DEFINES_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during reset
`define CPFM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define CPFM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cpfm_pkg.sv
// ----------------------------------------------------------------------------
// cpfm_pkg
// Widths, register codes and constants of the capture period frequency meter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpfm_pkg;

    localparam int STAMP_W      = 16;
    localparam int STAMP_FIELDS = 4;
    localparam int CLK_W        = 27;
    localparam int PPC_W        = 5;
    localparam int CNT_W        = 3;
    localparam int FRAC_W       = 8;
    localparam int FREQ_W       = 41;
    localparam int RPM_W        = 47;
    // clock * pulses * count (count never above four) * 2^FRAC_W
    localparam int PROD_W       = CLK_W + PPC_W;
    localparam int NUM_W        = PROD_W + 2 + FRAC_W;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = CLK_W;

    localparam int DEFAULT_MAX_CAPTURES = 4;

    localparam logic [CLK_W-1:0]  CLK_HZ_RESET = CLK_W'(390625);
    localparam logic [PPC_W-1:0]  PPC_RESET    = PPC_W'(16);
    localparam logic [FREQ_W-1:0] FREQ_MAX     = {FREQ_W{1'b1}};
    localparam int                RPM_FACTOR   = 60;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK_HZ    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_CAPTURE = CFG_IDX_W'(1);

endpackage

`default_nettype wire

// File: design/cpfm_interfaces.sv
// ----------------------------------------------------------------------------
// cpfm_interfaces
// Valid/ready channels for capture batches and frequency results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpfm_item_if
    import cpfm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               op;
    logic [CNT_W-1:0]   capture_count;
    logic [STAMP_W-1:0] capture_0;
    logic [STAMP_W-1:0] capture_1;
    logic [STAMP_W-1:0] capture_2;
    logic [STAMP_W-1:0] capture_3;
    logic [STAMP_W-1:0] start_tick;

    modport source (
        output valid, op, capture_count, capture_0, capture_1, capture_2, capture_3,
               start_tick,
        input  ready
    );
    modport sink (
        input  valid, op, capture_count, capture_0, capture_1, capture_2, capture_3,
               start_tick,
        output ready
    );
endinterface

interface cpfm_result_if
    import cpfm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              updated;
    logic [FREQ_W-1:0] freq_hz_q8;
    logic [RPM_W-1:0]  freq_rpm_q8;
    logic              zero_period;

    modport source (
        output valid, updated, freq_hz_q8, freq_rpm_q8, zero_period,
        input  ready
    );
    modport sink (
        input  valid, updated, freq_hz_q8, freq_rpm_q8, zero_period,
        output ready
    );
endinterface

`default_nettype wire

// File: design/cpfm_lane.sv
// ----------------------------------------------------------------------------
// cpfm_lane
// Wrapped tick difference of one capture stamp from the stamp before it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfm_lane
    import cpfm_pkg::*;
(
    input  wire logic               enable,
    input  wire logic [STAMP_W-1:0] stamp,
    input  wire logic [STAMP_W-1:0] prev,
    output logic      [STAMP_W-1:0] diff
);

    // modulo 2^16 subtraction covers timer wrap
    assign diff = enable ? (stamp - prev) : '0;

endmodule

`default_nettype wire

// File: design/cpfm_merge.sv
// ----------------------------------------------------------------------------
// cpfm_merge
// Sums the lane differences into elapsed ticks and picks the newest stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfm_merge
    import cpfm_pkg::*;
#(
    parameter int LANES     = DEFAULT_MAX_CAPTURES,
    parameter int ELAPSED_W = STAMP_W + $clog2(LANES)
) (
    input  wire logic [STAMP_W-1:0]   diffs  [LANES],
    input  wire logic [STAMP_W-1:0]   stamps [LANES],
    input  wire logic [CNT_W-1:0]     count,
    output logic      [ELAPSED_W-1:0] elapsed,
    output logic      [STAMP_W-1:0]   newest
);

    always_comb
    begin
        elapsed = '0;
        newest  = '0;
        for (int i = 0; i < LANES; i++)
        begin
            elapsed = elapsed + ELAPSED_W'(diffs[i]);
            if (count == CNT_W'(i + 1))
            begin
                newest = stamps[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: design/cpfm_divider.sv
// ----------------------------------------------------------------------------
// cpfm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfm_divider
    import cpfm_pkg::*;
#(
    parameter int DEN_W = STAMP_W + 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  acc_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;

    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, acc_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= STEP_W'(NUM_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
                done_reg <= (step_reg == STEP_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (step_reg != '0)
        begin
            // shift dividend out at the top, quotient bit in at the bottom
            acc_reg <= {acc_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

`default_nettype wire

// File: design/capture_period_frequency_meter.sv
// ----------------------------------------------------------------------------
// capture_period_frequency_meter
// Pulse frequency in Hz and RPM from batches of timer capture stamps.
// ----------------------------------------------------------------------------
// Restart and empty batches go from the idle state straight to the result state;
// a zero elapsed batch passes through ST_MUL1, and a measured batch through ST_MUL1,
// ST_MUL2 and the 42-step serial divider. One item at a time: a new batch is taken
// only in the idle state, after the result of the last one has been loaded.
// A finished result waits in the output register while the next item runs.
// Reset (asynchronous, active low) restores register defaults, clears state.
`default_nettype none

module capture_period_frequency_meter
    import cpfm_pkg::*;
#(
    parameter int MAX_CAPTURES = DEFAULT_MAX_CAPTURES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    cpfm_item_if.sink                  item,
    cpfm_result_if.source              result
);

    localparam int LANES     = (MAX_CAPTURES < STAMP_FIELDS) ? MAX_CAPTURES : STAMP_FIELDS;
    localparam int ELAPSED_W = STAMP_W + $clog2(LANES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL1   = 5'b00010,
        ST_MUL2   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_RESULT = 5'b10000
    } cpfm_state_t;

    cpfm_state_t          state_reg;
    cpfm_state_t          state_next;

    logic [CLK_W-1:0]     clk_hz_reg;
    logic [PPC_W-1:0]     ppc_reg;
    logic [STAMP_W-1:0]   last_stamp_reg;
    logic [FREQ_W-1:0]    held_freq_reg;

    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic                 res_upd_reg;
    logic [FREQ_W-1:0]    res_freq_reg;
    logic                 res_zp_reg;

    logic                 out_valid_reg;
    logic                 out_upd_reg;
    logic [FREQ_W-1:0]    out_freq_reg;
    logic [RPM_W-1:0]     out_rpm_reg;
    logic                 out_zp_reg;

    logic [STAMP_W-1:0]   stamps [STAMP_FIELDS];
    logic [STAMP_W-1:0]   lane_stamps [LANES];
    logic [STAMP_W-1:0]   lane_diffs  [LANES];
    logic [CNT_W-1:0]     count_sat;
    logic [ELAPSED_W-1:0] elapsed;
    logic [STAMP_W-1:0]   newest;

    logic                 accept;
    logic                 out_load;
    logic [PROD_W+CNT_W-1:0] prod_count;
    logic [NUM_W-1:0]     numerator;
    logic                 div_done;
    logic [NUM_W-1:0]     quotient;
    logic [FREQ_W-1:0]    quot_sat;
    logic [RPM_W-1:0]     rpm;

    assign stamps[0] = item.capture_0;
    assign stamps[1] = item.capture_1;
    assign stamps[2] = item.capture_2;
    assign stamps[3] = item.capture_3;

    assign count_sat = (item.capture_count > CNT_W'(LANES)) ? CNT_W'(LANES)
                                                            : item.capture_count;

    generate
        for (genvar i = 0; i < LANES; i++)
        begin : g_lane
            logic [STAMP_W-1:0] prev;
            if (i == 0)
            begin : g_first
                assign prev = last_stamp_reg;
            end
            else
            begin : g_rest
                assign prev = stamps[i-1];
            end
            assign lane_stamps[i] = stamps[i];

            cpfm_lane u_lane (
                .enable (count_sat > CNT_W'(i)),
                .stamp  (stamps[i]),
                .prev   (prev),
                .diff   (lane_diffs[i])
            );
        end
    endgenerate

    cpfm_merge #(
        .LANES     (LANES),
        .ELAPSED_W (ELAPSED_W)
    ) u_merge (
        .diffs   (lane_diffs),
        .stamps  (lane_stamps),
        .count   (count_sat),
        .elapsed (elapsed),
        .newest  (newest)
    );

    // count never exceeds four, so the top product bit is always clear
    assign prod_count = prod_reg * count_reg;
    assign numerator  = {prod_count[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

    cpfm_divider #(
        .DEN_W (ELAPSED_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_MUL2),
        .dividend (numerator),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign quot_sat = (|quotient[NUM_W-1:FREQ_W]) ? FREQ_MAX : quotient[FREQ_W-1:0];

    // times sixty as 64 - 4
    assign rpm = ({{(RPM_W-FREQ_W){1'b0}}, res_freq_reg} << 6)
               - ({{(RPM_W-FREQ_W){1'b0}}, res_freq_reg} << 2);

    assign accept   = item.valid && item.ready;
    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_MEASURE && count_sat != '0)
                    begin
                        state_next = ST_MUL1;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_MUL1:
            begin
                state_next = (elapsed_reg == '0) ? ST_RESULT : ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clk_hz_reg     <= CLK_HZ_RESET;
            ppc_reg        <= PPC_RESET;
            last_stamp_reg <= '0;
            held_freq_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we && cfg_index == REG_TIMER_CLOCK_HZ)
            begin
                clk_hz_reg <= cfg_wdata[CLK_W-1:0];
            end
            if (cfg_we && cfg_index == REG_PULSES_PER_CAPTURE)
            begin
                ppc_reg <= cfg_wdata[PPC_W-1:0];
            end

            if (accept && item.op == OP_RESTART)
            begin
                last_stamp_reg <= item.start_tick;
                held_freq_reg  <= '0;
            end
            else if (accept && count_sat != '0)
            begin
                last_stamp_reg <= newest;
            end
            else if (state_reg == ST_MUL1 && elapsed_reg == '0)
            begin
                held_freq_reg <= FREQ_MAX;
            end
            else if (state_reg == ST_DIV && div_done)
            begin
                held_freq_reg <= quot_sat;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                elapsed_reg <= elapsed;
                count_reg   <= count_sat;
                res_upd_reg <= 1'b0;
                res_zp_reg  <= 1'b0;
                // empty batch reports the held value, restart reports zero
                res_freq_reg <= (item.op == OP_RESTART) ? '0 : held_freq_reg;
            end
            ST_MUL1:
            begin
                prod_reg     <= clk_hz_reg * ppc_reg;
                res_upd_reg  <= 1'b1;
                res_zp_reg   <= (elapsed_reg == '0);
                res_freq_reg <= FREQ_MAX;
            end
            ST_DIV:
            begin
                res_freq_reg <= quot_sat;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_upd_reg  <= res_upd_reg;
            out_freq_reg <= res_freq_reg;
            out_rpm_reg  <= rpm;
            out_zp_reg   <= res_zp_reg;
        end
    end

    assign item.ready         = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.updated     = out_upd_reg;
    assign result.freq_hz_q8  = out_freq_reg;
    assign result.freq_rpm_q8 = out_rpm_reg;
    assign result.zero_period = out_zp_reg;

endmodule

`default_nettype wire

// File: design/cpfm_checker.sv
// ----------------------------------------------------------------------------
// cpfm_checker
// Port-level checks of the frequency meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "capture_period_frequency_meter_defines.svh"

module cpfm_checker
    import cpfm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic              updated,
    input wire logic [FREQ_W-1:0] freq_hz_q8,
    input wire logic [RPM_W-1:0]  freq_rpm_q8,
    input wire logic              zero_period
);

    logic [RPM_W-1:0] rpm_expected;

    assign rpm_expected = RPM_W'(freq_hz_q8) * RPM_W'(RPM_FACTOR);

    // one batch at a time: drop ready after a transaction
    `CPFM_ASSERT_NXT(a_busy_after_take, item_valid && item_ready, !item_ready,
        "input still ready after a transaction")

    `CPFM_ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid,
        "result dropped while stalled")

    `CPFM_ASSERT_IMP(a_zero_saturates, result_valid && zero_period,
        updated && freq_hz_q8 == FREQ_MAX, "zero period without saturated update")

    `CPFM_ASSERT_IMP(a_rpm_match, result_valid, freq_rpm_q8 == rpm_expected,
        "rpm value does not match frequency")

endmodule

bind capture_period_frequency_meter cpfm_checker u_cpfm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .updated      (result.updated),
    .freq_hz_q8   (result.freq_hz_q8),
    .freq_rpm_q8  (result.freq_rpm_q8),
    .zero_period  (result.zero_period)
);

`default_nettype wire

// File: tb/capture_period_frequency_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_period_frequency_meter_tb
// Self-checking bench for the capture period frequency meter. Capture batches
// go in over a valid/ready channel with random gaps, results come back with
// random stalls. Every result is checked against an in-bench predictor or, for
// typed directed rows, against the table value. The run covers the register corners,
// zero and large register values, wrapped stamps, zero elapsed time, empty batches and restarts.
// ----------------------------------------------------------------------------

module capture_period_frequency_meter_tb;
    import cpfm_pkg::*;

    localparam int CLK_HALF_NS  = 4;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int DRAIN_TAIL   = 60;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 38;
    localparam int PRINT_CAP    = 40;
    localparam int CAPT_LIMIT   = (DEFAULT_MAX_CAPTURES < STAMP_FIELDS) ?
                                  DEFAULT_MAX_CAPTURES : STAMP_FIELDS;

    typedef struct packed {
        logic               op;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] c0;
        logic [STAMP_W-1:0] c1;
        logic [STAMP_W-1:0] c2;
        logic [STAMP_W-1:0] c3;
        logic [STAMP_W-1:0] start;
    } batch_t;

    typedef struct packed {
        logic              updated;
        logic [FREQ_W-1:0] freq;
        logic [RPM_W-1:0]  rpm;
        logic              zero_period;
    } freq_result_t;

    typedef struct packed {
        batch_t       stim;
        logic         typed;
        freq_result_t want;
    } dir_row_t;

    // Default registers: one capture over one tick gives 1.6e9 in Q.8.
    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // empty batch straight after reset
        '{'{OP_MEASURE, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
          1'b1, '{1'b0, 41'd0, 47'd0, 1'b0}},
        // restart at the top of the counter; stamp fields are ignored
        '{'{OP_RESTART, 3'd7, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0000, 16'hFFFF},
          1'b1, '{1'b0, 41'd0, 47'd0, 1'b0}},
        // wrap from 0xFFFF to 0x0000: one tick
        '{'{OP_MEASURE, 3'd1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
          1'b1, '{1'b1, 41'd1600000000, 47'd96000000000, 1'b0}},
        // same stamp again: zero elapsed saturates
        '{'{OP_MEASURE, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
          1'b1, '{1'b1, FREQ_MAX, 47'd131941395333060, 1'b1}},
        // empty batch returns the held saturated value
        '{'{OP_MEASURE, 3'd0, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555},
          1'b1, '{1'b0, FREQ_MAX, 47'd131941395333060, 1'b0}},
        '{'{OP_RESTART, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1234},
          1'b1, '{1'b0, 41'd0, 47'd0, 1'b0}},
        '{'{OP_MEASURE, 3'd4, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h0000},
          1'b1, '{1'b1, FREQ_MAX, 47'd131941395333060, 1'b1}},
        '{'{OP_MEASURE, 3'd4, 16'h1235, 16'h1236, 16'h1237, 16'h1238, 16'h0000},
          1'b1, '{1'b1, 41'd1600000000, 47'd96000000000, 1'b0}},
        // four full-length periods, the longest elapsed a batch can carry
        '{'{OP_MEASURE, 3'd4, 16'h1237, 16'h1236, 16'h1235, 16'h1234, 16'h0000},
          1'b0, '0},
        // counts above four saturate
        '{'{OP_MEASURE, 3'd7, 16'h2000, 16'h3000, 16'h4000, 16'h5000, 16'hFFFF},
          1'b0, '0},
        '{'{OP_MEASURE, 3'd5, 16'h6000, 16'h7000, 16'h8000, 16'h9000, 16'h0000},
          1'b0, '0},
        '{'{OP_MEASURE, 3'd6, 16'hA000, 16'hB000, 16'hC000, 16'hD000, 16'h0000},
          1'b0, '0},
        '{'{OP_RESTART, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
          1'b1, '{1'b0, 41'd0, 47'd0, 1'b0}},
        '{'{OP_MEASURE, 3'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
          1'b0, '0},
        '{'{OP_MEASURE, 3'd2, 16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000},
          1'b0, '0},
        '{'{OP_MEASURE, 3'd3, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h0000},
          1'b0, '0},
        '{'{OP_MEASURE, 3'd1, 16'h8001, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000},
          1'b0, '0},
        '{'{OP_MEASURE, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
          1'b0, '0},
        '{'{OP_RESTART, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000},
          1'b1, '{1'b0, 41'd0, 47'd0, 1'b0}},
        '{'{OP_MEASURE, 3'd2, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000},
          1'b1, '{1'b1, FREQ_MAX, 47'd131941395333060, 1'b1}},
        // unused stamp fields carry junk
        '{'{OP_MEASURE, 3'd1, 16'h8001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
          1'b1, '{1'b1, 41'd1600000000, 47'd96000000000, 1'b0}}
    };

    // register settings per phase; -1 picks a random in-range value
    localparam int PHASE_CLK [PHASES] = '{1, 100000000, 100000000, 1, 134217727,
                                          0, 5000, -1, -1, 390625};
    localparam int PHASE_PPC [PHASES] = '{1, 16, 1, 16, 31, 7, 0, -1, -1, 16};

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cpfm_item_if   item_ch ();
    cpfm_result_if res_ch ();

    capture_period_frequency_meter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    // predictor state
    logic [CLK_W-1:0]   pred_clk_hz;
    logic [PPC_W-1:0]   pred_ppc;
    logic [STAMP_W-1:0] pred_last_stamp;
    logic [FREQ_W-1:0]  pred_held_freq;

    freq_result_t pending_freq [$];
    bit           no_idle;
    int           errors;
    int           sent;
    int           restarts;
    int           empty_batches;
    int           saturations;
    int           settings_run;

    initial clk = 1'b0;
    always #(CLK_HALF_NS) clk = ~clk;

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("capture_period_frequency_meter_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic freq_result_t meter_predict(input batch_t b);
        freq_result_t      r;
        logic [STAMP_W-1:0] stamps [STAMP_FIELDS];
        logic [STAMP_W-1:0] diff;
        int unsigned       n;
        int unsigned       i;
        longint unsigned   elapsed;
        longint unsigned   num;
        longint unsigned   q;
        r = '0;
        stamps[0] = b.c0;
        stamps[1] = b.c1;
        stamps[2] = b.c2;
        stamps[3] = b.c3;
        if (b.op == OP_RESTART)
        begin
            pred_last_stamp = b.start;
            pred_held_freq  = '0;
            restarts++;
            return r;
        end
        n = b.count;
        if (n > CAPT_LIMIT)
            n = CAPT_LIMIT;
        if (n == 0)
        begin
            r.freq = pred_held_freq;
            r.rpm  = RPM_W'(longint'(pred_held_freq) * RPM_FACTOR);
            empty_batches++;
            return r;
        end
        elapsed = 0;
        for (i = 0; i < n; i++)
        begin
            diff = stamps[i] - pred_last_stamp;
            elapsed += diff;
            pred_last_stamp = stamps[i];
        end
        if (elapsed == 0)
        begin
            q = FREQ_MAX;
            r.zero_period = 1'b1;
            saturations++;
        end
        else
        begin
            num = longint'(pred_clk_hz) * pred_ppc * n * 256;
            q = num / elapsed;
            if (q > FREQ_MAX)
                q = FREQ_MAX;
        end
        r.updated = 1'b1;
        r.freq    = FREQ_W'(q);
        r.rpm     = RPM_W'(q * RPM_FACTOR);
        pred_held_freq = r.freq;
        return r;
    endfunction

    // stamps advance from the running last stamp, mostly by plausible periods
    function automatic batch_t gen_batch();
        batch_t             b;
        logic [STAMP_W-1:0] cursor;
        logic [STAMP_W-1:0] stamps [STAMP_FIELDS];
        int                 r;
        int                 mode;
        int                 i;
        b.op    = OP_MEASURE;
        b.start = STAMP_W'($urandom);
        b.count = CNT_W'($urandom);
        for (i = 0; i < STAMP_FIELDS; i++)
            stamps[i] = STAMP_W'($urandom);
        r = $urandom_range(99);
        if (r < 8)
            b.op = OP_RESTART;
        else if (r < 13)
            b.count = '0;
        else
        begin
            b.count = (r < 18) ? CNT_W'($urandom_range(7, 5)) : CNT_W'($urandom_range(4, 1));
            mode = $urandom_range(99);
            cursor = pred_last_stamp;
            for (i = 0; i < STAMP_FIELDS; i++)
            begin
                r = $urandom_range(99);
                if (mode < 4 || (r >= 75 && r < 85))
                    cursor = cursor;
                else if (r < 55)
                    cursor = cursor + STAMP_W'($urandom_range(2000, 1));
                else if (r < 75)
                    cursor = STAMP_W'($urandom);
                else if (r < 93)
                    cursor = cursor + STAMP_W'($urandom_range(65535, 65000));
                else
                    cursor = cursor + STAMP_W'($urandom_range(20, 1));
                stamps[i] = cursor;
            end
        end
        b.c0 = stamps[0];
        b.c1 = stamps[1];
        b.c2 = stamps[2];
        b.c3 = stamps[3];
        return b;
    endfunction

    task automatic push_batch(input batch_t b, input logic typed, input freq_result_t want);
        int           gap;
        freq_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.op            <= b.op;
        item_ch.capture_count <= b.count;
        item_ch.capture_0     <= b.c0;
        item_ch.capture_1     <= b.c1;
        item_ch.capture_2     <= b.c2;
        item_ch.capture_3     <= b.c3;
        item_ch.start_tick    <= b.start;
        do @(posedge clk); while (!item_ch.ready);
        predicted = meter_predict(b);
        pending_freq.push_back(typed ? want : predicted);
        sent++;
    endtask

    // drop valid and hold until every outstanding result is back
    task automatic hold_and_drain();
        item_ch.valid <= 1'b0;
        while (pending_freq.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] clk_data,
                              input logic [CFG_DATA_W-1:0] ppc_data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIMER_CLOCK_HZ;
        cfg_wdata <= clk_data;
        @(posedge clk);
        cfg_index <= REG_PULSES_PER_CAPTURE;
        cfg_wdata <= ppc_data;
        @(posedge clk);
        cfg_we <= 1'b0;
        pred_clk_hz = clk_data[CLK_W-1:0];
        pred_ppc    = ppc_data[PPC_W-1:0];
        settings_run++;
    endtask

    // result side: stall at random, with free-running stretches
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        freq_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_freq.size() == 0)
                report_mismatch("result with nothing outstanding", res_ch.freq_hz_q8, 0);
            else
            begin
                want = pending_freq.pop_front();
                if (res_ch.updated !== want.updated)
                    report_mismatch("updated", res_ch.updated, want.updated);
                if (res_ch.freq_hz_q8 !== want.freq)
                    report_mismatch("freq_hz_q8", res_ch.freq_hz_q8, want.freq);
                if (res_ch.freq_rpm_q8 !== want.rpm)
                    report_mismatch("freq_rpm_q8", res_ch.freq_rpm_q8, want.rpm);
                if (res_ch.zero_period !== want.zero_period)
                    report_mismatch("zero_period", res_ch.zero_period, want.zero_period);
            end
        end
    end

    initial
    begin : stimulus
        int                    row;
        int                    ph;
        int                    k;
        logic [CFG_DATA_W-1:0] clk_data;
        logic [CFG_DATA_W-1:0] ppc_data;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        item_ch.valid         = 1'b0;
        item_ch.op            = OP_MEASURE;
        item_ch.capture_count = '0;
        item_ch.capture_0     = '0;
        item_ch.capture_1     = '0;
        item_ch.capture_2     = '0;
        item_ch.capture_3     = '0;
        item_ch.start_tick    = '0;
        pred_clk_hz           = CLK_HZ_RESET;
        pred_ppc              = PPC_RESET;
        pred_last_stamp       = '0;
        pred_held_freq        = '0;
        no_idle               = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++)
            push_batch(DIRECTED[row].stim, DIRECTED[row].typed, DIRECTED[row].want);

        for (ph = 0; ph < PHASES; ph++)
        begin
            hold_and_drain();
            if (PHASE_CLK[ph] < 0)
            begin
                clk_data = CFG_DATA_W'($urandom_range(100000000, 1));
                // junk above the pulse count field must be ignored
                ppc_data = CFG_DATA_W'(($urandom << PPC_W) | $urandom_range(16, 1));
            end
            else
            begin
                clk_data = CFG_DATA_W'(PHASE_CLK[ph]);
                ppc_data = CFG_DATA_W'(PHASE_PPC[ph]);
            end
            write_regs(clk_data, ppc_data);
            no_idle = (ph % 4 == 1);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // in phase two, let the pipeline run dry once mid-phase
                if (ph == 2 && k == PHASE_ITEMS / 2)
                    hold_and_drain();
                push_batch(gen_batch(), 1'b0, '0);
            end
            no_idle = 1'b0;
        end

        hold_and_drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        $display("covered %0d transactions under %0d register settings besides the default",
                 sent, settings_run);
        $display("restarts %0d, empty batches %0d, zero-period saturations %0d, mismatches %0d",
                 restarts, empty_batches, saturations, errors);
        if (errors == 0 && pending_freq.size() == 0)
            $display("capture_period_frequency_meter_tb: PASS");
        else
            $display("capture_period_frequency_meter_tb: FAIL");
        $finish;
    end

endmodule
